FILE: src/cdp_pkg.sv
// Shared types and constants for the coordinate digit projection block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package cdp_pkg;
    localparam int CRD_W     = 32;
    localparam int NUM_W     = 16;
    localparam int DIM_W     = 3;
    localparam int IO_DIMS   = 6;
    localparam int TERM_W    = 54;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int DEF_MAX_TERMS = 7;
    localparam int DEF_NUM_DIMS  = 6;

    // two quotient bits per divider stage
    localparam int DIV_STG   = CRD_W / 2;
    // select, divide, modulo, multiply
    localparam int LANE_LAT  = 1 + DIV_STG + DIV_STG + 1;
    // two adder stages after the lanes
    localparam int PIPE_LAT  = LANE_LAT + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = CFG_IDX_W'(0);

    typedef struct packed {
        logic [NUM_W-1:0] mult;
        logic [DIM_W-1:0] dst;
        logic [NUM_W-1:0] modu;
        logic [NUM_W-1:0] divi;
        logic [DIM_W-1:0] src;
    } t_term;

    typedef logic [IO_DIMS-1:0][CRD_W-1:0] t_crd_vec;
endpackage
`default_nettype wire

FILE: src/cdp_src_if.sv
// Input channel: valid/ready handshake with six source coordinates.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cdp_src_if import cdp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CRD_W-1:0] src_block;
    logic [CRD_W-1:0] src_row;
    logic [CRD_W-1:0] src_col;
    logic [CRD_W-1:0] src_reduction;
    logic [CRD_W-1:0] src_participant;
    logic [CRD_W-1:0] src_value;

    modport source (output valid, src_block, src_row, src_col, src_reduction,
                    src_participant, src_value, input ready);
    modport sink (input valid, src_block, src_row, src_col, src_reduction,
                  src_participant, src_value, output ready);
endinterface
`default_nettype wire

FILE: src/cdp_dst_if.sv
// Output channel: valid/ready handshake with six projected coordinates.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cdp_dst_if import cdp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CRD_W-1:0] out_block;
    logic [CRD_W-1:0] out_row;
    logic [CRD_W-1:0] out_col;
    logic [CRD_W-1:0] out_reduction;
    logic [CRD_W-1:0] out_participant;
    logic [CRD_W-1:0] out_value;

    modport source (output valid, out_block, out_row, out_col, out_reduction,
                    out_participant, out_value, input ready);
    modport sink (input valid, out_block, out_row, out_col, out_reduction,
                  out_participant, out_value, output ready);
endinterface
`default_nettype wire

FILE: src/cdp_lane.sv
// One projection term: source select, pipelined divide, modulo and multiply.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdp_lane import cdp_pkg::*; #(
    parameter int NUM_DIMS = DEF_NUM_DIMS
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire t_crd_vec         i_src,
    input  wire t_term            i_term,
    input  wire logic             i_on,
    output logic [CRD_W-1:0]      o_prod
);
    // one restoring step: shift in the top dividend bit, subtract if it fits
    function automatic logic [NUM_W+CRD_W-1:0] f_step(input logic [NUM_W-1:0] rem,
                                                      input logic [CRD_W-1:0] w,
                                                      input logic [NUM_W-1:0] d);
        logic [NUM_W:0] t;
        logic [NUM_W:0] diff;
        t    = {rem, w[CRD_W-1]};
        diff = t - {1'b0, d};
        if (!diff[NUM_W]) begin
            return {diff[NUM_W-1:0], w[CRD_W-2:0], 1'b1};
        end
        return {t[NUM_W-1:0], w[CRD_W-2:0], 1'b0};
    endfunction

    function automatic logic [NUM_W+CRD_W-1:0] f_two(input logic [NUM_W-1:0] rem,
                                                     input logic [CRD_W-1:0] w,
                                                     input logic [NUM_W-1:0] d);
        logic [NUM_W+CRD_W-1:0] s;
        s = f_step(rem, w, d);
        return f_step(s[NUM_W+CRD_W-1:CRD_W], s[CRD_W-1:0], d);
    endfunction

    logic [NUM_W-1:0] w_div;
    logic [NUM_W-1:0] w_mod;
    logic             w_src_ok;
    logic [CRD_W-1:0] w_sel;
    logic [CRD_W-1:0] w_dig;

    logic [NUM_W-1:0] r_dr [0:DIV_STG];
    logic [CRD_W-1:0] r_dw [0:DIV_STG];
    logic [NUM_W-1:0] r_mr [1:DIV_STG];
    logic [CRD_W-1:0] r_mw [1:DIV_STG];
    logic [CRD_W-1:0] r_q  [1:DIV_STG];
    logic [CRD_W-1:0] r_prod;

    assign w_div    = (i_term.divi == '0) ? NUM_W'(1) : i_term.divi;
    assign w_mod    = (i_term.modu == '0) ? NUM_W'(1) : i_term.modu;
    assign w_src_ok = ({1'b0, i_term.src} < (DIM_W+1)'(NUM_DIMS))
                   && ({1'b0, i_term.src} < (DIM_W+1)'(IO_DIMS));
    assign w_sel    = w_src_ok ? i_src[i_term.src] : '0;
    // zero modulus: keep the quotient itself
    assign w_dig    = (i_term.modu == '0) ? r_q[DIV_STG]
                                          : {{(CRD_W-NUM_W){1'b0}}, r_mr[DIV_STG]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dr[0] <= '0;
            r_dw[0] <= w_sel;
            for (int k = 1; k <= DIV_STG; k++) begin
                {r_dr[k], r_dw[k]} <= f_two(r_dr[k-1], r_dw[k-1], w_div);
            end
            {r_mr[1], r_mw[1]} <= f_two('0, r_dw[DIV_STG], w_mod);
            r_q[1] <= r_dw[DIV_STG];
            for (int k = 2; k <= DIV_STG; k++) begin
                {r_mr[k], r_mw[k]} <= f_two(r_mr[k-1], r_mw[k-1], w_mod);
                r_q[k] <= r_q[k-1];
            end
            r_prod <= i_on ? CRD_W'(w_dig * {{(CRD_W-NUM_W){1'b0}}, i_term.mult}) : '0;
        end
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

FILE: src/coordinate_digit_projection.sv
// Pipeline from input beat to output beat: 1 select, 16 divide, 16 modulo,
// 1 multiply and 2 adder stages; throughput one beat per cycle while not stalled.
// The pipeline advances as a whole; it stalls only when the output register
// holds a beat that is not taken. Synchronous active-low reset clears valid
// bits and configuration registers; data registers are not reset.
// Depends on cdp_pkg, cdp_src_if, cdp_dst_if and cdp_lane.
`timescale 1ns / 1ps
`default_nettype none
module coordinate_digit_projection import cdp_pkg::*; #(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int NUM_DIMS  = DEF_NUM_DIMS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [TERM_W-1:0]     i_cfg_data,
    cdp_src_if.sink                    i_src,
    cdp_dst_if.source                  o_dst
);
    localparam int HALF = (MAX_TERMS + 1) / 2;

    // configuration
    logic [CNT_W-1:0] r_active;
    t_term            r_term [MAX_TERMS];
    logic [CNT_W-1:0] w_cnt;

    // pipeline control
    logic                r_vld_pipe [PIPE_LAT];
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_adv;

    t_crd_vec         w_src;
    logic [CRD_W-1:0] w_prod [MAX_TERMS];
    t_crd_vec         n_sa, n_sb;
    t_crd_vec         r_sa, r_sb;
    t_crd_vec         r_out;

    // config writes: active term count at its own index, terms after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int i = 0; i < MAX_TERMS; i++) begin
                r_term[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ACTIVE) begin
                r_active <= i_cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < MAX_TERMS; i++) begin
                if (i_cfg_idx == CFG_IDX_W'(i + 1)) begin
                    r_term[i] <= i_cfg_data;
                end
            end
        end
    end

    // saturate the term count to the lanes present
    assign w_cnt = (r_active > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : r_active;

    // advance whenever the output slot is free or being drained
    assign w_adv       = !r_vld[PIPE_LAT-1] || o_dst.ready;
    assign i_src.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_src.valid};
        end
    end

    always_comb begin
        for (int s = 0; s < PIPE_LAT; s++) begin
            r_vld_pipe[s] = r_vld[s];
        end
    end

    assign w_src[0] = i_src.src_block;
    assign w_src[1] = i_src.src_row;
    assign w_src[2] = i_src.src_col;
    assign w_src[3] = i_src.src_reduction;
    assign w_src[4] = i_src.src_participant;
    assign w_src[5] = i_src.src_value;

    // one lane per term; an idle lane contributes zero
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_lane
        cdp_lane #(
            .NUM_DIMS (NUM_DIMS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_src  (w_src),
            .i_term (r_term[g]),
            .i_on   (CNT_W'(g) < w_cnt),
            .o_prod (w_prod[g])
        );
    end

    // route each product to its destination; out-of-range destinations match nothing
    always_comb begin
        n_sa = '0;
        n_sb = '0;
        for (int d = 0; d < IO_DIMS; d++) begin
            if (d < NUM_DIMS) begin
                for (int i = 0; i < HALF; i++) begin
                    if (r_term[i].dst == DIM_W'(d)) begin
                        n_sa[d] = n_sa[d] + w_prod[i];
                    end
                end
                for (int i = HALF; i < MAX_TERMS; i++) begin
                    if (r_term[i].dst == DIM_W'(d)) begin
                        n_sb[d] = n_sb[d] + w_prod[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
            for (int d = 0; d < IO_DIMS; d++) begin
                r_out[d] <= r_sa[d] + r_sb[d];
            end
        end
    end

    assign o_dst.valid           = r_vld_pipe[PIPE_LAT-1];
    assign o_dst.out_block       = r_out[0];
    assign o_dst.out_row         = r_out[1];
    assign o_dst.out_col         = r_out[2];
    assign o_dst.out_reduction   = r_out[3];
    assign o_dst.out_participant = r_out[4];
    assign o_dst.out_value       = r_out[5];

`ifndef SYNTH
    // a beat moves one stage on every advance
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_adv) |-> r_vld[PIPE_LAT-1] == $past(r_vld[PIPE_LAT-2]))
        else $error("valid bit did not advance");
    // a stall freezes every valid bit
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_adv) |-> $stable(r_vld))
        else $error("pipeline moved during stall");
    // nothing leaves right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_dst.valid)
        else $error("output valid after reset");
`endif
endmodule
`default_nettype wire
